FILE: hw/rtl/aes128_block_cipher_ecb_cbc_assert.svh
// ---------------------------------------------------------------------------
// AES assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef AES128_BLOCK_CIPHER_ECB_CBC_ASSERT_SVH
`define AES128_BLOCK_CIPHER_ECB_CBC_ASSERT_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define AES_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("AES assertion failed: same-cycle implication");
// Consequent must hold in the cycle after the antecedent.
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("AES assertion failed: next-cycle implication");
`else
`define AES_ASSERT_IMP(label, clk, rst, ante, cons)
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/aes_pkg.sv
// ---------------------------------------------------------------------------
// AES package
// Shared constants, S-box tables, field helpers and inter-module structs.
// ---------------------------------------------------------------------------
package aes_pkg;

   localparam int BLOCK_W    = 128;
   localparam int HALF_W     = 64;
   localparam int NUM_ROUNDS = 10;
   localparam int NUM_RKEYS  = 11;
   localparam int RK_ADDR_W  = 4;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IV_HIGH       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IV_LOW        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DECRYPT_MODE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAINING_MODE = 3'd5;

   localparam logic [7:0] GF_POLY    = 8'h1b;
   localparam logic [7:0] RCON_FIRST = 8'h01;
   localparam logic [RK_ADDR_W-1:0] LAST_ROUND = RK_ADDR_W'(NUM_ROUNDS);

   typedef struct packed {
      logic start;
      logic decrypt;
      logic out_free;
   } eng_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } eng_stat_type;

   localparam logic [7:0] FWD_SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
      8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
      8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
      8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
      8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
      8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
      8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
      8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
      8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
      8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
      8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
      8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
      8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
      8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
      8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
      8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
      8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,
      8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,
      8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,
      8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,
      8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,
      8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,
      8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,
      8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,
      8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,
      8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,
      8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,
      8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,
      8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,
      8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,
      8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,
      8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,
      8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] sub_fwd(input logic [7:0] x);
      return FWD_SBOX[x];
   endfunction

   function automatic logic [7:0] sub_inv(input logic [7:0] x);
      return INV_SBOX[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
   endfunction

   // Round key slot used by a given round; decryption walks the schedule backwards.
   function automatic logic [RK_ADDR_W-1:0] rk_index(input logic dec,
                                                     input logic [RK_ADDR_W-1:0] rnd);
      return dec ? (LAST_ROUND - rnd) : rnd;
   endfunction

endpackage

FILE: hw/rtl/aes_key_sched.sv
// ---------------------------------------------------------------------------
// AES key schedule
// Expands the cipher key into eleven round keys held in two 64-bit memories.
// ---------------------------------------------------------------------------
module aes_key_sched
   import aes_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 key_load,
   input  logic [BLOCK_W-1:0]   key,
   input  logic [RK_ADDR_W-1:0] rd_addr,
   output logic [BLOCK_W-1:0]   rd_key,
   output logic                 ready
);

   logic [HALF_W-1:0]    rk_hi_mem_ff [NUM_RKEYS];
   logic [HALF_W-1:0]    rk_lo_mem_ff [NUM_RKEYS];
   logic [HALF_W-1:0]    rd_hi_ff;
   logic [HALF_W-1:0]    rd_lo_ff;
   logic                 ready_ff;
   logic [RK_ADDR_W-1:0] cnt_ff;
   logic [BLOCK_W-1:0]   cur_ff;
   logic [7:0]           rcon_ff;
   logic [BLOCK_W-1:0]   wkey;
   logic [BLOCK_W-1:0]   next_rk;

   always_comb begin
      logic [31:0] w0, w1, w2, w3, t;
      w0 = cur_ff[127:96];
      w1 = cur_ff[95:64];
      w2 = cur_ff[63:32];
      w3 = cur_ff[31:0];
      t  = {sub_fwd(w3[23:16]) ^ rcon_ff, sub_fwd(w3[15:8]), sub_fwd(w3[7:0]),
            sub_fwd(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      next_rk = {w0, w1, w2, w3};
   end

   assign wkey = (cnt_ff == '0) ? key : next_rk;

   always_ff @(posedge clock) begin
      if (!ready_ff) begin
         rk_hi_mem_ff[cnt_ff] <= wkey[BLOCK_W-1:HALF_W];
         rk_lo_mem_ff[cnt_ff] <= wkey[HALF_W-1:0];
         cur_ff               <= wkey;
         rcon_ff              <= (cnt_ff == '0) ? RCON_FIRST : xtime(rcon_ff);
      end
      rd_hi_ff <= rk_hi_mem_ff[rd_addr];
      rd_lo_ff <= rk_lo_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || key_load) begin
         ready_ff <= 1'b0;
         cnt_ff   <= '0;
      end else if (!ready_ff) begin
         if (cnt_ff == LAST_ROUND) begin
            ready_ff <= 1'b1;
            cnt_ff   <= '0;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   assign rd_key = {rd_hi_ff, rd_lo_ff};
   assign ready  = ready_ff;

endmodule

FILE: hw/rtl/aes_engine.sv
// ---------------------------------------------------------------------------
// AES round engine
// One shared round unit iterated over ten rounds, state held in a register.
// ---------------------------------------------------------------------------
module aes_engine
   import aes_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  eng_ctrl_type         ctrl,
   input  logic [BLOCK_W-1:0]   init_state,
   input  logic [BLOCK_W-1:0]   rk,
   output logic [RK_ADDR_W-1:0] rk_addr,
   output eng_stat_type         stat,
   output logic [BLOCK_W-1:0]   result
);

   logic [BLOCK_W-1:0]   state_ff;
   logic [RK_ADDR_W-1:0] round_ff;
   logic                 busy_ff;
   logic                 last;
   logic                 advance;
   logic                 done;
   logic [BLOCK_W-1:0]   rnd_out;

   function automatic logic [BLOCK_W-1:0] shift_rows(input logic [BLOCK_W-1:0] s,
                                                     input logic inv);
      logic [BLOCK_W-1:0] t;
      int src;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = inv ? (((c + 4 - r) & 3) * 4 + r) : (((c + r) & 3) * 4 + r);
            t[127 - 8 * (c * 4 + r) -: 8] = s[127 - 8 * src -: 8];
         end
      end
      return t;
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] m1 [4];
      logic [7:0] m2 [4];
      logic [7:0] m3 [4];
      logic [7:0] m4 [4];
      logic [31:0] o;
      for (int k = 0; k < 4; k++) begin
         a[k]  = col[31 - 8 * k -: 8];
         x2[k] = xtime(a[k]);
         x4[k] = xtime(x2[k]);
         x8[k] = xtime(x4[k]);
         // Forward uses weights 2, 3, 1, 1; inverse 14, 11, 13, 9.
         m1[k] = inv ? (x8[k] ^ x4[k] ^ x2[k]) : x2[k];
         m2[k] = inv ? (x8[k] ^ x2[k] ^ a[k]) : (x2[k] ^ a[k]);
         m3[k] = inv ? (x8[k] ^ x4[k] ^ a[k]) : a[k];
         m4[k] = inv ? (x8[k] ^ a[k]) : a[k];
      end
      o = '0;
      for (int r = 0; r < 4; r++) begin
         o[31 - 8 * r -: 8] = m1[r] ^ m2[(r + 1) & 3] ^ m3[(r + 2) & 3] ^ m4[(r + 3) & 3];
      end
      return o;
   endfunction

   always_comb begin
      logic [BLOCK_W-1:0] s;
      s = state_ff;
      if (!ctrl.decrypt) begin
         for (int i = 0; i < 16; i++) s[127 - 8 * i -: 8] = sub_fwd(s[127 - 8 * i -: 8]);
         s = shift_rows(s, 1'b0);
         if (!last) begin
            for (int c = 0; c < 4; c++) s[127 - 32 * c -: 32] = mix_col(s[127 - 32 * c -: 32],
                                                                       1'b0);
         end
         s = s ^ rk;
      end else begin
         s = shift_rows(s, 1'b1);
         for (int i = 0; i < 16; i++) s[127 - 8 * i -: 8] = sub_inv(s[127 - 8 * i -: 8]);
         s = s ^ rk;
         if (!last) begin
            for (int c = 0; c < 4; c++) s[127 - 32 * c -: 32] = mix_col(s[127 - 32 * c -: 32],
                                                                       1'b1);
         end
      end
      rnd_out = s;
   end

   assign last    = (round_ff == LAST_ROUND);
   assign advance = busy_ff && (!last || ctrl.out_free);
   assign done    = busy_ff && last && ctrl.out_free;

   // Address the key needed in the next cycle; the memory read is registered.
   always_comb begin
      if (ctrl.start) begin
         rk_addr = rk_index(ctrl.decrypt, RK_ADDR_W'(1));
      end else if (busy_ff && !done) begin
         rk_addr = rk_index(ctrl.decrypt, advance ? (round_ff + 1'b1) : round_ff);
      end else begin
         rk_addr = rk_index(ctrl.decrypt, '0);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         state_ff <= init_state ^ rk;
      end else if (advance) begin
         state_ff <= rnd_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         round_ff <= '0;
      end else if (ctrl.start) begin
         busy_ff  <= 1'b1;
         round_ff <= RK_ADDR_W'(1);
      end else if (done) begin
         busy_ff  <= 1'b0;
         round_ff <= '0;
      end else if (advance) begin
         round_ff <= round_ff + 1'b1;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done;
   assign result    = rnd_out;

endmodule

FILE: hw/rtl/aes128_block_cipher_ecb_cbc.sv
// ---------------------------------------------------------------------------
// AES-128 block cipher, ECB and CBC
// Top level: configuration registers, chaining, round engine and key store.
// ---------------------------------------------------------------------------
// AES-128 encrypt or decrypt of one 128-bit block per request beat, with ECB
// or CBC chaining selected by register. The accepting beat adds the first
// round key, then the single round unit runs once per round for ten rounds,
// each round's key fetched ahead from the round key memories through a
// registered read. A new request beat is taken only once the engine is no
// longer busy; the result sits in an output register, so the next request
// beat is taken while it waits. After reset or a key register write the
// key schedule fills the round key memories, and after any configuration
// write the first round key is refetched; no request is accepted meanwhile.
// Byte 0 of every block, key and IV is the top byte of its high half.
// ---------------------------------------------------------------------------
`include "aes128_block_cipher_ecb_cbc_assert.svh"

module aes128_block_cipher_ecb_cbc
   import aes_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [HALF_W-1:0]    req_block_high,
   input  logic [HALF_W-1:0]    req_block_low,
   input  logic                 req_first_block,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [HALF_W-1:0]    rsp_result_high,
   output logic [HALF_W-1:0]    rsp_result_low,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [HALF_W-1:0]    csr_data
);

   logic [HALF_W-1:0]    key_hi_ff, key_lo_ff, iv_hi_ff, iv_lo_ff;
   logic                 decrypt_ff, cbc_ff;
   logic                 primed_ff;
   logic [BLOCK_W-1:0]   chain_ff;
   logic [BLOCK_W-1:0]   pend_chain_ff;
   logic [HALF_W-1:0]    rsp_hi_ff, rsp_lo_ff;
   logic                 rsp_valid_ff;

   logic                 csr_fire, req_fire, key_load, key_ready;
   logic [BLOCK_W-1:0]   blk, chain_eff, init_state, rk, result, rsp_in;
   logic [RK_ADDR_W-1:0] rk_addr;
   eng_ctrl_type         eng_ctrl;
   eng_stat_type         eng_stat;

   // Configuration writes are always taken at once.
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign key_load  = csr_fire && ((csr_index == CSR_KEY_HIGH) || (csr_index == CSR_KEY_LOW));

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff  <= '0;
         key_lo_ff  <= '0;
         iv_hi_ff   <= '0;
         iv_lo_ff   <= '0;
         decrypt_ff <= 1'b0;
         cbc_ff     <= 1'b0;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_KEY_HIGH:      key_hi_ff  <= csr_data;
            CSR_KEY_LOW:       key_lo_ff  <= csr_data;
            CSR_IV_HIGH:       iv_hi_ff   <= csr_data;
            CSR_IV_LOW:        iv_lo_ff   <= csr_data;
            CSR_DECRYPT_MODE:  decrypt_ff <= csr_data[0];
            CSR_CHAINING_MODE: cbc_ff     <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // primed_ff registers that the key schedule is ready and that no configuration
   // write is being taken, so the round key register holds the first round key.
   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
      end else begin
         primed_ff <= key_ready && !csr_fire;
      end
   end

   assign req_ready = primed_ff && !eng_stat.busy;
   assign req_fire  = req_valid && req_ready;

   assign blk        = {req_block_high, req_block_low};
   // A first block in CBC mode starts again from the IV.
   assign chain_eff  = (cbc_ff && req_first_block) ? {iv_hi_ff, iv_lo_ff} : chain_ff;
   // Encryption in CBC folds the chain value into the plaintext on entry.
   assign init_state = blk ^ ((cbc_ff && !decrypt_ff) ? chain_eff : '0);

   assign eng_ctrl.start    = req_fire;
   assign eng_ctrl.decrypt  = decrypt_ff;
   assign eng_ctrl.out_free = !rsp_valid_ff || rsp_ready;

   aes_key_sched u_key_sched (
      .clock    (clock),
      .reset    (reset),
      .key_load (key_load),
      .key      ({key_hi_ff, key_lo_ff}),
      .rd_addr  (rk_addr),
      .rd_key   (rk),
      .ready    (key_ready)
   );

   aes_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (eng_ctrl),
      .init_state (init_state),
      .rk         (rk),
      .rk_addr    (rk_addr),
      .stat       (eng_stat),
      .result     (result)
   );

   // Decryption in CBC folds the previous ciphertext into the output.
   assign rsp_in = result ^ ((cbc_ff && decrypt_ff) ? pend_chain_ff : '0);

   always_ff @(posedge clock) begin
      if (req_fire && cbc_ff && decrypt_ff) begin
         pend_chain_ff <= chain_eff;
      end
      if (eng_stat.done) begin
         rsp_hi_ff <= rsp_in[BLOCK_W-1:HALF_W];
         rsp_lo_ff <= rsp_in[HALF_W-1:0];
      end
   end

   // The chain value follows the ciphertext: the input block when decrypting,
   // the result block when encrypting. ECB leaves it untouched.
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else if (req_fire && cbc_ff && decrypt_ff) begin
         chain_ff <= blk;
      end else if (eng_stat.done && cbc_ff && !decrypt_ff) begin
         chain_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_stat.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_high = rsp_hi_ff;
   assign rsp_result_low  = rsp_lo_ff;

   `AES_ASSERT_NEXT(a_start_busy, clock, reset, req_fire, eng_stat.busy)
   `AES_ASSERT_NEXT(a_done_valid, clock, reset, eng_stat.done, rsp_valid_ff)
   `AES_ASSERT_IMP(a_ready_keys, clock, reset, req_ready, key_ready)
   `AES_ASSERT_IMP(a_no_overwrite, clock, reset, eng_stat.done, !rsp_valid_ff || rsp_ready)

endmodule
